/* rtl/vlcplt_pkg.sv */
package vlcplt_pkg;

    localparam int TBL_CNT_DEF    = 4;
    localparam int WIN_W          = 12;
    localparam int LEN_W          = 4;
    localparam int SYM_W          = 8;

    typedef enum logic [1:0] {
        FUNC_INIT   = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_LOOKUP = 2'd2
    } func_t;

    typedef enum logic {
        ST_IDLE,
        ST_FILL
    } state_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [1:0]         table_req;
        logic [3:0]         table_bits;
        logic [SYM_W-1:0]   symbol;
        logic [LEN_W-1:0]   code_length;
        logic [11:0]        code_bits;
        logic [11:0]        window;
    } req_t;

    typedef struct packed {
        logic [SYM_W-1:0]   found_symbol;
        logic [LEN_W-1:0]   found_length;
        logic               status;
    } rsp_t;

    typedef struct packed {
        logic [LEN_W-1:0]   length;
        logic [SYM_W-1:0]   symbol;
    } entry_t;

endpackage

/* rtl/vlcplt_ram.sv */
module vlcplt_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/vlc_prefix_lookup_table.sv */
// channel | direction | valid     | stall     | payload
// req     | in        | req_valid | req_stall | req (req_t: func .. window)
// rsp     | out       | rsp_valid | rsp_stall | rsp (rsp_t: symbol, length, status)
//
// Lookups pass through the registered RAM read (stage s1), then the rsp register; a new one may follow at once.
// Init fills 2^width entries and insert fills 2^(width-length) entries, one per
// cycle through the single write port of the entry RAM; req_stall is high during the fill.
// Reset clears all table widths to zero, so every table reads empty until its init;
// the entry RAM needs no clearing pass.
// A stalled rsp holds one result and one read in flight; req_stall rises until rsp moves.
module vlc_prefix_lookup_table
    import vlcplt_pkg::*;
#(
    parameter int TBL_CNT = TBL_CNT_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int TAB_W     = (TBL_CNT > 1) ? $clog2(TBL_CNT) : 1;
    localparam int TAB_COUNT = 1 << TAB_W;
    localparam int IDX_W     = WIN_W;
    localparam int ADDR_W    = TAB_W + IDX_W;
    localparam int DEPTH     = 1 << ADDR_W;

    state_t               state_reg, state_next;
    logic [LEN_W-1:0]     width_reg [TAB_COUNT];
    logic [TAB_W-1:0]     fill_tab_reg, fill_tab_next;
    logic [IDX_W-1:0]     fill_idx_reg, fill_idx_next;
    logic [IDX_W-1:0]     fill_end_reg, fill_end_next;
    entry_t               fill_data_reg, fill_data_next;

    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_lookup_reg, s1_lookup_next;
    logic                 s1_status_reg, s1_status_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;

    logic                 out_adv;
    logic                 accept;
    logic                 tab_ok;
    logic [TAB_W-1:0]     tab_sel;
    logic [LEN_W-1:0]     tab_width;
    logic [LEN_W-1:0]     init_bits;
    logic [LEN_W-1:0]     ins_shift;
    logic [IDX_W:0]       init_span;
    logic [IDX_W:0]       ins_span;
    logic [IDX_W-1:0]     ins_start;
    logic [IDX_W-1:0]     look_idx;
    logic                 ins_bad;
    logic                 width_we;
    logic                 ram_we;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t               rd_entry;

    assign out_adv   = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE) || (s1_valid_reg && !out_adv);
    assign accept    = req_valid && !req_stall;

    assign tab_ok    = {3'b000, req.table_req} < 5'(TBL_CNT);
    assign tab_sel   = TAB_W'(req.table_req);
    assign tab_width = width_reg[tab_sel];

    assign init_bits = (req.table_bits == '0) ? LEN_W'(1) :
                       (req.table_bits > LEN_W'(WIN_W)) ? LEN_W'(WIN_W) : req.table_bits;
    assign init_span = (IDX_W+1)'(1) << init_bits;
    assign ins_shift = tab_width - req.code_length;
    assign ins_span  = (IDX_W+1)'(1) << ins_shift;
    assign ins_start = IDX_W'({req.code_bits} << ins_shift);
    assign ins_bad   = (req.code_length > tab_width) ||
                       ((req.code_bits >> req.code_length) != '0);
    assign look_idx  = IDX_W'(req.window >> (LEN_W'(WIN_W) - tab_width));

    assign ram_re    = accept;
    assign ram_raddr = {tab_sel, look_idx};
    assign ram_we    = (state_reg == ST_FILL);
    assign ram_waddr = {fill_tab_reg, fill_idx_reg};
    assign rd_entry  = entry_t'(ram_rdata);

    vlcplt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (fill_data_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        fill_tab_next  = fill_tab_reg;
        fill_idx_next  = fill_idx_reg;
        fill_end_next  = fill_end_reg;
        fill_data_next = fill_data_reg;
        width_we       = 1'b0;
        s1_lookup_next = 1'b0;
        s1_status_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && tab_ok)
                begin
                    case (req.func)
                        FUNC_INIT:
                        begin
                            width_we       = 1'b1;
                            fill_tab_next  = tab_sel;
                            fill_idx_next  = '0;
                            fill_end_next  = IDX_W'(init_span - (IDX_W+1)'(1));
                            fill_data_next = '0;
                            state_next     = ST_FILL;
                        end
                        FUNC_INSERT:
                        begin
                            if (req.code_length != '0)
                            begin
                                if (ins_bad)
                                begin
                                    s1_status_next = 1'b1;
                                end
                                else
                                begin
                                    fill_tab_next  = tab_sel;
                                    fill_idx_next  = ins_start;
                                    fill_end_next  = ins_start |
                                                     IDX_W'(ins_span - (IDX_W+1)'(1));
                                    fill_data_next = '{length: req.code_length,
                                                       symbol: req.symbol};
                                    state_next     = ST_FILL;
                                end
                            end
                        end
                        FUNC_LOOKUP:
                        begin
                            s1_lookup_next = (tab_width != '0);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                if (fill_idx_reg == fill_end_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    fill_idx_next = fill_idx_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (out_adv)
        begin
            rsp_valid_next = s1_valid_reg;
            s1_valid_next  = 1'b0;
            if (s1_lookup_reg)
            begin
                rsp_next.found_length = rd_entry.length;
                rsp_next.found_symbol = (rd_entry.length != '0) ? rd_entry.symbol : '0;
                rsp_next.status       = 1'b0;
            end
            else
            begin
                rsp_next.found_length = '0;
                rsp_next.found_symbol = '0;
                rsp_next.status       = s1_status_reg;
            end
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < TAB_COUNT; i++)
            begin
                width_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (width_we)
            begin
                width_reg[tab_sel] <= init_bits;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fill_tab_reg  <= fill_tab_next;
        fill_idx_reg  <= fill_idx_next;
        fill_end_reg  <= fill_end_next;
        fill_data_reg <= fill_data_next;
        rsp_reg       <= rsp_next;
        if (accept)
        begin
            s1_lookup_reg <= s1_lookup_next;
            s1_status_reg <= s1_status_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_no_accept_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> req_stall)
        else $error("item accepted during fill");

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (fill_idx_reg <= fill_end_reg))
        else $error("fill index past end");

    a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_adv) |=> s1_valid_reg)
        else $error("pending read lost under stall");

    a_empty_symbol: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.found_length == '0) |-> (rsp_reg.found_symbol == '0))
        else $error("symbol reported with zero length");

    a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status) |-> (rsp_reg.found_length == '0))
        else $error("rejected insert carries a length");

endmodule
